FILE: rtl/core/bsm_pkg.sv
// Shared types and constants for the bank switch mapper with scanline IRQ.
// Used by bsm_ctrl, bsm_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bsm_pkg;

  typedef enum logic [2:0] {
    KIND_CPU_RD  = 3'd0,
    KIND_CPU_WR  = 3'd1,
    KIND_PPU_RD  = 3'd2,
    KIND_PPU_WR  = 3'd3,
    KIND_TICK    = 3'd4,
    KIND_IRQ_SET = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_PRG_RAM = 2'd2,
    TGT_CHR     = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    MIR_VERTICAL    = 2'd0,
    MIR_HORIZONTAL  = 2'd1,
    MIR_FOUR_SCREEN = 2'd2
  } mirror_e;

  // Register windows above 0x8000, selected by address bits [14:13]
  localparam logic [1:0] REGION_BANK    = 2'd0;
  localparam logic [1:0] REGION_MIRROR  = 2'd1;
  localparam logic [1:0] REGION_IRQ_LAT = 2'd2;
  localparam logic [1:0] REGION_IRQ_EN  = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_BANKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_BANKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MIRROR   = 2'd3;

  localparam logic [8:0] PRG_BANKS_RST = 9'd32;
  localparam logic [8:0] CHR_BANKS_RST = 9'd128;
  localparam logic [8:0] MAX_BANKS     = 9'd256;

  localparam int unsigned OFFSET_W  = 21;
  localparam int unsigned REM_STEPS = 8;

  typedef struct packed {
    logic start;  // capture the accepted transaction and update mapper state
    logic step;   // one restoring remainder step
    logic load;   // move the finished result into the output register
  } bsm_cmd_t;

endpackage

FILE: rtl/core/bsm_ctrl.sv
// Controller of the mapper: sequences accept, remainder steps and result load.
// Depends on bsm_pkg; drives bsm_datapath through bsm_cmd_t.
`timescale 1ns / 1ps

module bsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bsm_pkg::bsm_cmd_t cmd_o
);
  import bsm_pkg::*;

  localparam int unsigned STEP_W = $clog2(REM_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_cnt_q;
  logic                valid_q;

  always_comb begin
    cmd_o.start = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step  = (state_q == ST_RUN);
    cmd_o.load  = (state_q == ST_DONE) && (!valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_cnt_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q    <= ST_RUN;
            step_cnt_q <= '0;
          end
        end
        ST_RUN: begin
          step_cnt_q <= step_cnt_q + 1'b1;
          if (step_cnt_q == STEP_W'(REM_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd_o.load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // hold the result until taken, refill on load
      if (cmd_o.load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

FILE: rtl/core/bsm_datapath.sv
// Datapath of the mapper: configuration, mapper and IRQ state, bank selection,
// restoring remainder unit and offset build. Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_datapath #(
  parameter int unsigned PRG_BANK_BYTES = 8192,
  parameter int unsigned CHR_BANK_BYTES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bsm_pkg::bsm_cmd_t              cmd_i,
  input  logic [2:0]                     kind_i,
  input  logic [15:0]                    bus_addr_i,
  input  logic [7:0]                     wdata_i,
  input  logic                           cfg_we_i,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           mapped_o,
  output logic [1:0]                     target_o,
  output logic [bsm_pkg::OFFSET_W-1:0]   phys_offset_o,
  output logic                           irq_line_o,
  output logic [1:0]                     mirroring_o
);
  import bsm_pkg::*;

  localparam int unsigned PRG_OFF_W = $clog2(PRG_BANK_BYTES);
  localparam int unsigned CHR_OFF_W = $clog2(CHR_BANK_BYTES);
  // ceil(2^32 / bytes): exact quotient for any 16-bit address
  localparam logic [31:0] PRG_RECIP =
    32'(((64'd1 << 32) + 64'(PRG_BANK_BYTES) - 64'd1) / 64'(PRG_BANK_BYTES));
  localparam logic [31:0] CHR_RECIP =
    32'(((64'd1 << 32) + 64'(CHR_BANK_BYTES) - 64'd1) / 64'(CHR_BANK_BYTES));

  // configuration
  logic [8:0] prg_banks_q, prg_banks_d;
  logic [8:0] chr_banks_q, chr_banks_d;
  logic       ram_present_q, ram_present_d;
  mirror_e    init_mirror_q, init_mirror_d;

  // mapper and IRQ state
  logic [2:0] bank_sel_q, bank_sel_d;
  logic       prg_swap_q, prg_swap_d;
  logic       chr_inv_q, chr_inv_d;
  logic [7:0] bank_num_q [8];
  logic [7:0] bank_num_d [8];
  logic [7:0] ctr_latch_q, ctr_latch_d;
  logic [7:0] irq_cnt_q, irq_cnt_d;
  logic       irq_en_q, irq_en_d;
  logic       ctr_reload_q, ctr_reload_d;
  logic       irq_pend_q, irq_pend_d;
  mirror_e    mirror_q, mirror_d;

  // per-transaction working registers
  logic       item_mapped_q;
  target_e    item_target_q;
  logic [15:0] addr_q;
  logic [7:0] dividend_q;
  logic [8:0] divisor_q;
  logic [7:0] rem_q;
  logic [15:0] prg_quo_q, chr_quo_q;
  logic [PRG_OFF_W-1:0] prg_low_q;
  logic [CHR_OFF_W-1:0] chr_low_q;

  // output register
  logic                mapped_q;
  target_e             target_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                irq_line_q;
  mirror_e             mirroring_q;

  logic       item_mapped;
  target_e    item_target;
  logic [8:0] prg_count, chr_count;
  logic [7:0] prg_last, prg_second;
  logic [7:0] prg_bank, chr_bank, chr_sel_bank;
  logic [2:0] chr_win, chr_idx;
  logic [7:0] tick_cnt;
  mirror_e    cfg_mirror;
  logic [8:0] rem_trial;
  logic [7:0] rem_next;
  logic [47:0] prg_prod, chr_prod;
  logic [15:0] prg_addr_rem, chr_addr_rem;
  logic [31:0] prg_off_full, chr_off_full;
  logic [OFFSET_W-1:0] offset_d;

  function automatic logic [8:0] clamp_count(logic [8:0] n);
    logic [8:0] c;
    c = n;
    if (n == 9'd0) begin
      c = 9'd1;
    end else if (n > MAX_BANKS) begin
      c = MAX_BANKS;
    end
    return c;
  endfunction

  assign prg_count  = clamp_count(prg_banks_q);
  assign chr_count  = clamp_count(chr_banks_q);
  assign prg_last   = 8'(prg_count - 9'd1);
  assign prg_second = prg_last - 8'd1;

  // PRG window select: R6/R7/second-last/last, R6 and second-last swap in mode 1
  always_comb begin
    case (bus_addr_i[14:13])
      2'd1:    prg_bank = bank_num_q[7];
      2'd3:    prg_bank = prg_last;
      default: begin
        if ((bus_addr_i[14:13] == 2'd0) != prg_swap_q) begin
          prg_bank = bank_num_q[6];
        end else begin
          prg_bank = prg_second;
        end
      end
    endcase
  end

  // CHR window select: two 2 KiB pairs and four 1 KiB banks, halves swap on invert
  assign chr_win      = bus_addr_i[12:10] ^ {chr_inv_q, 2'b00};
  assign chr_idx      = chr_win[2] ? (chr_win - 3'd2) : {2'b00, chr_win[1]};
  assign chr_sel_bank = bank_num_q[chr_idx];
  always_comb begin
    if (chr_win[2]) begin
      chr_bank = chr_sel_bank;
    end else if (chr_win[0]) begin
      chr_bank = chr_sel_bank | 8'h01;
    end else begin
      chr_bank = chr_sel_bank & 8'hFE;
    end
  end

  // access decode
  always_comb begin
    item_mapped = 1'b0;
    item_target = TGT_NONE;
    case (kind_i) inside
      KIND_CPU_RD, KIND_CPU_WR: begin
        if (bus_addr_i[15:13] == 3'b011 && ram_present_q) begin
          item_mapped = 1'b1;
          item_target = TGT_PRG_RAM;
        end else if (bus_addr_i[15]) begin
          item_mapped = 1'b1;
          if (kind_i == KIND_CPU_RD) begin
            item_target = TGT_PRG_ROM;
          end
        end
      end
      KIND_PPU_RD, KIND_PPU_WR: begin
        if (bus_addr_i[15:13] == 3'b000) begin
          item_mapped = 1'b1;
          item_target = TGT_CHR;
        end
      end
      default: ;
    endcase
  end

  assign tick_cnt = (irq_cnt_q == 8'd0 || ctr_reload_q) ? ctr_latch_q : irq_cnt_q - 8'd1;
  assign cfg_mirror = (cfg_wdata_i[1:0] == 2'd3) ? MIR_FOUR_SCREEN : mirror_e'(cfg_wdata_i[1:0]);

  // next state of configuration and mapper registers
  always_comb begin
    prg_banks_d   = prg_banks_q;
    chr_banks_d   = chr_banks_q;
    ram_present_d = ram_present_q;
    init_mirror_d = init_mirror_q;
    bank_sel_d    = bank_sel_q;
    prg_swap_d    = prg_swap_q;
    chr_inv_d     = chr_inv_q;
    bank_num_d    = bank_num_q;
    ctr_latch_d   = ctr_latch_q;
    irq_cnt_d     = irq_cnt_q;
    irq_en_d      = irq_en_q;
    ctr_reload_d  = ctr_reload_q;
    irq_pend_d    = irq_pend_q;
    mirror_d      = mirror_q;

    if (cmd_i.start) begin
      case (kind_i)
        KIND_CPU_WR: begin
          if (bus_addr_i[15]) begin
            unique case (bus_addr_i[14:13])
              REGION_BANK: begin
                if (!bus_addr_i[0]) begin
                  bank_sel_d = wdata_i[2:0];
                  prg_swap_d = wdata_i[6];
                  chr_inv_d  = wdata_i[7];
                end else begin
                  bank_num_d[bank_sel_q] = wdata_i;
                end
              end
              REGION_MIRROR: begin
                // PRG RAM protect on odd addresses is ignored
                if (!bus_addr_i[0] && mirror_q != MIR_FOUR_SCREEN) begin
                  mirror_d = mirror_e'({1'b0, wdata_i[0]});
                end
              end
              REGION_IRQ_LAT: begin
                if (!bus_addr_i[0]) begin
                  ctr_latch_d = wdata_i;
                end else begin
                  irq_cnt_d    = 8'd0;
                  ctr_reload_d = 1'b1;
                end
              end
              REGION_IRQ_EN: begin
                if (!bus_addr_i[0]) begin
                  irq_en_d   = 1'b0;
                  irq_pend_d = 1'b0;
                end else begin
                  irq_en_d = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        KIND_TICK: begin
          irq_cnt_d    = tick_cnt;
          ctr_reload_d = 1'b0;
          if (tick_cnt == 8'd0 && irq_en_q) begin
            irq_pend_d = 1'b1;
          end
        end
        KIND_IRQ_SET: irq_pend_d = wdata_i[0];
        default: ;
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRG_ROM_BANKS: prg_banks_d   = cfg_wdata_i;
        CFG_CHR_ROM_BANKS: chr_banks_d   = cfg_wdata_i;
        CFG_PRG_RAM:       ram_present_d = cfg_wdata_i[0];
        CFG_INIT_MIRROR: begin
          init_mirror_d = cfg_mirror;
          mirror_d      = cfg_mirror;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_banks_q   <= PRG_BANKS_RST;
      chr_banks_q   <= CHR_BANKS_RST;
      ram_present_q <= 1'b1;
      init_mirror_q <= MIR_VERTICAL;
      bank_sel_q    <= '0;
      prg_swap_q    <= 1'b0;
      chr_inv_q     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_num_q[i] <= '0;
      end
      ctr_latch_q   <= '0;
      irq_cnt_q     <= '0;
      irq_en_q      <= 1'b0;
      ctr_reload_q  <= 1'b0;
      irq_pend_q    <= 1'b0;
      mirror_q      <= MIR_VERTICAL;
    end else begin
      prg_banks_q   <= prg_banks_d;
      chr_banks_q   <= chr_banks_d;
      ram_present_q <= ram_present_d;
      init_mirror_q <= init_mirror_d;
      bank_sel_q    <= bank_sel_d;
      prg_swap_q    <= prg_swap_d;
      chr_inv_q     <= chr_inv_d;
      bank_num_q    <= bank_num_d;
      ctr_latch_q   <= ctr_latch_d;
      irq_cnt_q     <= irq_cnt_d;
      irq_en_q      <= irq_en_d;
      ctr_reload_q  <= ctr_reload_d;
      irq_pend_q    <= irq_pend_d;
      mirror_q      <= mirror_d;
    end
  end

  // restoring remainder: one dividend bit per step
  assign rem_trial = {rem_q, dividend_q[7]};
  assign rem_next  = (rem_trial >= divisor_q) ? 8'(rem_trial - divisor_q) : rem_trial[7:0];

  // byte within bank by reciprocal multiply, two register stages behind addr_q
  assign prg_prod     = 48'(addr_q) * 48'(PRG_RECIP);
  assign chr_prod     = 48'(addr_q) * 48'(CHR_RECIP);
  assign prg_addr_rem = addr_q - 16'(32'(prg_quo_q) * 32'(PRG_BANK_BYTES));
  assign chr_addr_rem = addr_q - 16'(32'(chr_quo_q) * 32'(CHR_BANK_BYTES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_mapped_q <= item_mapped;
      item_target_q <= item_target;
      addr_q        <= bus_addr_i;
      rem_q         <= '0;
      if (item_target == TGT_CHR) begin
        dividend_q <= chr_bank;
        divisor_q  <= chr_count;
      end else begin
        dividend_q <= prg_bank;
        divisor_q  <= prg_count;
      end
    end else if (cmd_i.step) begin
      rem_q      <= rem_next;
      dividend_q <= {dividend_q[6:0], 1'b0};
    end
    prg_quo_q <= prg_prod[47:32];
    chr_quo_q <= chr_prod[47:32];
    prg_low_q <= prg_addr_rem[PRG_OFF_W-1:0];
    chr_low_q <= chr_addr_rem[CHR_OFF_W-1:0];
  end

  assign prg_off_full = 32'(rem_q) * 32'(PRG_BANK_BYTES) + 32'(prg_low_q);
  assign chr_off_full = 32'(rem_q) * 32'(CHR_BANK_BYTES) + 32'(chr_low_q);

  always_comb begin
    case (item_target_q)
      TGT_PRG_ROM: offset_d = prg_off_full[OFFSET_W-1:0];
      TGT_PRG_RAM: offset_d = OFFSET_W'(addr_q[12:0]);
      TGT_CHR:     offset_d = chr_off_full[OFFSET_W-1:0];
      default:     offset_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mapped_q    <= item_mapped_q;
      target_q    <= item_target_q;
      offset_q    <= offset_d;
      irq_line_q  <= irq_pend_q;
      mirroring_q <= mirror_q;
    end
  end

  assign mapped_o      = mapped_q;
  assign target_o      = target_q;
  assign phys_offset_o = offset_q;
  assign irq_line_o    = irq_line_q;
  assign mirroring_o   = mirroring_q;

endmodule

FILE: rtl/core/bank_switch_mapper_scanline_irq.sv
// Bank switching mapper with scanline IRQ counter: top level.
// Depends on bsm_pkg, bsm_ctrl and bsm_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bus transaction:
//   kind_i, bus_addr_i, wdata_i. Output channel (out_valid_o / out_stall_i)
//   returns one result per transaction: mapped_o, target_o, phys_offset_o,
//   irq_line_o, mirroring_o. Mapper register writes, scanline ticks and
//   IRQ set/clear take effect at the edge the transaction is accepted.
//   From acceptance to out_valid_o, the accepting edge captures, eight steps
//   of the restoring remainder reduce the bank number by the bank count, and
//   the load builds the offset into the output register. One transaction is
//   in work at a time, so a new one is taken only once the previous one has
//   run its eight-step remainder loop and load and the controller is idle.
//   A finished result waits in the output register while out_stall_i is
//   high; the next transaction is still accepted and its result is held
//   back until the register is free.
//   Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) is written between
//   transactions. Reset clears the handshake state and loads the default
//   configuration and mapper state; no clearing pass is needed.
`timescale 1ns / 1ps

module bank_switch_mapper_scanline_irq #(
  parameter int unsigned PRG_BANK_BYTES = 8192,
  parameter int unsigned CHR_BANK_BYTES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     kind_i,
  input  logic [15:0]                    bus_addr_i,
  input  logic [7:0]                     wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           mapped_o,
  output logic [1:0]                     target_o,
  output logic [bsm_pkg::OFFSET_W-1:0]   phys_offset_o,
  output logic                           irq_line_o,
  output logic [1:0]                     mirroring_o,
  input  logic                           cfg_we_i,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bsm_pkg::*;

  bsm_cmd_t cmd;

  bsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bsm_datapath #(
    .PRG_BANK_BYTES (PRG_BANK_BYTES),
    .CHR_BANK_BYTES (CHR_BANK_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .bus_addr_i    (bus_addr_i),
    .wdata_i       (wdata_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mapped_o      (mapped_o),
    .target_o      (target_o),
    .phys_offset_o (phys_offset_o),
    .irq_line_o    (irq_line_o),
    .mirroring_o   (mirroring_o)
  );

`ifndef SYNTHESIS
  // an accepted transaction blocks the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a transaction");

  // a fresh result frees the input channel in the same cycle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result loaded while controller still busy");

  // unmapped results carry no target and no offset
  a_unmapped_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mapped_o) |-> (target_o == TGT_NONE && phys_offset_o == '0))
    else $error("unmapped result with target or offset");
`endif

endmodule
